// ===== rtl/rdc_pkg.sv =====
`default_nettype none
package rdc_pkg;

  localparam int SW_W       = 13;
  localparam int POS_W      = 22;
  localparam int DIR_W      = 18;
  localparam int RAY_W      = 19;
  localparam int CELL_W     = 6;
  localparam int DIST_W     = 32;
  localparam int CFG_DW     = 22;
  localparam int CFG_AW     = 3;
  localparam int EXTRA_BITS = 13;
  localparam int SQ_SHIFT   = 26;
  localparam int RAD_W      = 64;
  localparam int ROOT_W     = 32;

  localparam int RAY_MAX = 262143;
  localparam int RAY_MIN = -262144;

  localparam logic [SW_W-1:0]         RST_SCREEN_WIDTH = 13'd640;
  localparam logic [POS_W-1:0]        RST_POS          = 22'd0;
  localparam logic signed [DIR_W-1:0] RST_DIR_X        = 18'sd65536;
  localparam logic signed [DIR_W-1:0] RST_DIR_Y        = 18'sd0;
  localparam logic signed [DIR_W-1:0] RST_PLANE_X      = 18'sd0;
  localparam logic signed [DIR_W-1:0] RST_PLANE_Y      = 18'sd43254;

  typedef enum logic [CFG_AW-1:0] {
    CFG_SCREEN_WIDTH,
    CFG_POS_X,
    CFG_POS_Y,
    CFG_DIR_X,
    CFG_DIR_Y,
    CFG_PLANE_X,
    CFG_PLANE_Y
  } cfg_idx_t;

  typedef struct packed {
    logic signed [RAY_W-1:0] rx;
    logic signed [RAY_W-1:0] ry;
    logic [RAY_W-1:0]        ax;
    logic [RAY_W-1:0]        ay;
    logic                    ovfx;
    logic                    ovfy;
  } rdc_ctx_t;

  typedef struct packed {
    logic signed [RAY_W-1:0] ray_dir_x;
    logic signed [RAY_W-1:0] ray_dir_y;
    logic [CELL_W-1:0]       cell_x;
    logic [CELL_W-1:0]       cell_y;
    logic                    step_neg_x;
    logic                    step_neg_y;
    logic [DIST_W-1:0]       delta_dist_x;
    logic [DIST_W-1:0]       delta_dist_y;
    logic [DIST_W-1:0]       side_dist_x;
    logic [DIST_W-1:0]       side_dist_y;
  } rdc_result_t;

endpackage
`default_nettype wire

// ===== rtl/rdc_in_if.sv =====
`default_nettype none
interface rdc_in_if #(
  parameter int COLUMN_BITS = 12
) ();
  logic                   valid;
  logic                   ready;
  logic [COLUMN_BITS-1:0] column;

  modport source (output valid, output column, input ready);
  modport sink (input valid, input column, output ready);
endinterface
`default_nettype wire

// ===== rtl/rdc_out_if.sv =====
`default_nettype none
interface rdc_out_if import rdc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [RAY_W-1:0] ray_dir_x;
  logic signed [RAY_W-1:0] ray_dir_y;
  logic [CELL_W-1:0]       cell_x;
  logic [CELL_W-1:0]       cell_y;
  logic                    step_neg_x;
  logic                    step_neg_y;
  logic [DIST_W-1:0]       delta_dist_x;
  logic [DIST_W-1:0]       delta_dist_y;
  logic [DIST_W-1:0]       side_dist_x;
  logic [DIST_W-1:0]       side_dist_y;

  modport source (output valid, output ray_dir_x, output ray_dir_y, output cell_x,
                  output cell_y, output step_neg_x, output step_neg_y,
                  output delta_dist_x, output delta_dist_y, output side_dist_x,
                  output side_dist_y, input ready);
  modport sink (input valid, input ray_dir_x, input ray_dir_y, input cell_x,
                input cell_y, input step_neg_x, input step_neg_y,
                input delta_dist_x, input delta_dist_y, input side_dist_x,
                input side_dist_y, output ready);
endinterface
`default_nettype wire

// ===== rtl/rdc_div_cell.sv =====
`default_nettype none
module rdc_div_cell #(
  parameter int DW = 13,
  parameter int QW = 29
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] div_i,
  input  logic [DW-1:0] rem_i,
  input  logic [QW-1:0] nq_i,
  output logic [DW-1:0] rem_o,
  output logic [QW-1:0] nq_o
);

  logic [DW:0]   r2;
  logic          ge;
  logic [DW-1:0] rem_nxt;
  logic [QW-1:0] nq_nxt;
  logic [DW-1:0] rem_r;
  logic [QW-1:0] nq_r;

  always_comb begin
    r2      = {rem_i, nq_i[QW-1]};
    ge      = (r2 >= {1'b0, div_i});
    rem_nxt = ge ? DW'(r2 - {1'b0, div_i}) : r2[DW-1:0];
    nq_nxt  = {nq_i[QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      nq_r  <= nq_nxt;
    end
  end

  assign rem_o = rem_r;
  assign nq_o  = nq_r;

endmodule
`default_nettype wire

// ===== rtl/rdc_sqrt_cell.sv =====
`default_nettype none
module rdc_sqrt_cell import rdc_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [RAD_W-1:0]  rad_i,
  input  logic [ROOT_W:0]   rem_i,
  input  logic [ROOT_W-1:0] root_i,
  output logic [RAD_W-1:0]  rad_o,
  output logic [ROOT_W:0]   rem_o,
  output logic [ROOT_W-1:0] root_o
);

  logic [ROOT_W+2:0] rem_sh;
  logic [ROOT_W+2:0] trial;
  logic              ge;
  logic [ROOT_W:0]   rem_nxt;
  logic [ROOT_W-1:0] root_nxt;
  logic [RAD_W-1:0]  rad_nxt;
  logic [RAD_W-1:0]  rad_r;
  logic [ROOT_W:0]   rem_r;
  logic [ROOT_W-1:0] root_r;

  always_comb begin
    rem_sh   = {rem_i, rad_i[RAD_W-1 -: 2]};
    trial    = {1'b0, root_i, 2'b01};
    ge       = (rem_sh >= trial);
    rem_nxt  = ge ? (ROOT_W+1)'(rem_sh - trial) : rem_sh[ROOT_W:0];
    root_nxt = {root_i[ROOT_W-2:0], ge};
    rad_nxt  = {rad_i[RAD_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= rad_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign rad_o  = rad_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;

endmodule
`default_nettype wire

// ===== rtl/rdc_out_buf.sv =====
`default_nettype none
module rdc_out_buf import rdc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_i,
  input  rdc_result_t      data_i,
  output logic             space_o,
  rdc_out_if.source        out_ch
);

  rdc_result_t ent_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        pop;
  rdc_result_t head;

  assign pop     = out_ch.valid && out_ch.ready;
  assign space_o = (cnt_r != 2'd2);
  assign head    = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push_i ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = 2'(cnt_r + {1'b0, push_i} - {1'b0, pop});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      ent_r[wr_ptr_r] <= data_i;
    end
  end

  assign out_ch.valid        = (cnt_r != 2'd0);
  assign out_ch.ray_dir_x    = head.ray_dir_x;
  assign out_ch.ray_dir_y    = head.ray_dir_y;
  assign out_ch.cell_x       = head.cell_x;
  assign out_ch.cell_y       = head.cell_y;
  assign out_ch.step_neg_x   = head.step_neg_x;
  assign out_ch.step_neg_y   = head.step_neg_y;
  assign out_ch.delta_dist_x = head.delta_dist_x;
  assign out_ch.delta_dist_y = head.delta_dist_y;
  assign out_ch.side_dist_x  = head.side_dist_x;
  assign out_ch.side_dist_y  = head.side_dist_y;

endmodule
`default_nettype wire

// ===== rtl/raycast_dda_column_setup_unit.sv =====
// DDA ray setup for one screen column per request: camera x, ray direction, start cell,
// step signs, per-cell delta distances and initial side distances; ray and distance values
// are fixed point with FRAC_BITS fraction bits. One column is taken every clock while the
// output buffer has space. The pipeline is built from three rows of one-bit cells: the
// camera-x divider (one quotient bit per cell), the 32-cell square root of the ray length
// and the 32-cell delta dividers. A two-entry output buffer keeps the pipeline moving
// while results wait; the whole row holds only when that buffer is full. Write the camera
// registers only with no request in flight.
`default_nettype none
module raycast_dda_column_setup_unit import rdc_pkg::*; #(
  parameter int MAP_SIZE    = 64,
  parameter int FRAC_BITS   = 16,
  parameter int COLUMN_BITS = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  rdc_in_if.sink            in_ch,
  rdc_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_idx,
  input  logic [CFG_DW-1:0] cfg_data
);

  localparam int FB   = FRAC_BITS;
  localparam int NUMW = COLUMN_BITS + 1 + FB;
  localparam int CAMW = NUMW + 1;
  localparam int PRW  = DIR_W + CAMW;
  localparam int SUMW = PRW - FB + 1;
  localparam int PROW = FB + 1 + DIST_W;

  localparam int S_M  = NUMW;
  localparam int S_R  = S_M + 1;
  localparam int S_Q1 = S_R + 1;
  localparam int S_Q2 = S_Q1 + 1;
  localparam int S_SQ = S_Q2 + 1;
  localparam int S_D0 = S_SQ + ROOT_W;
  localparam int S_DV = S_D0 + 1;
  localparam int S_E  = S_DV + DIST_W;
  localparam int S_F  = S_E + 1;
  localparam int NST  = S_F + 1;

  localparam logic signed [CAMW-1:0] ONE_CAM = CAMW'(1) << FB;
  localparam logic [FB:0]            ONE_FR  = (FB+1)'(1) << FB;

  logic [SW_W-1:0]         sw_r;
  logic [POS_W-1:0]        pos_x_r, pos_y_r;
  logic signed [DIR_W-1:0] dir_x_r, dir_y_r, plane_x_r, plane_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r      <= RST_SCREEN_WIDTH;
      pos_x_r   <= RST_POS;
      pos_y_r   <= RST_POS;
      dir_x_r   <= RST_DIR_X;
      dir_y_r   <= RST_DIR_Y;
      plane_x_r <= RST_PLANE_X;
      plane_y_r <= RST_PLANE_Y;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_SCREEN_WIDTH: sw_r      <= cfg_data[SW_W-1:0];
        CFG_POS_X:        pos_x_r   <= cfg_data[POS_W-1:0];
        CFG_POS_Y:        pos_y_r   <= cfg_data[POS_W-1:0];
        CFG_DIR_X:        dir_x_r   <= $signed(cfg_data[DIR_W-1:0]);
        CFG_DIR_Y:        dir_y_r   <= $signed(cfg_data[DIR_W-1:0]);
        CFG_PLANE_X:      plane_x_r <= $signed(cfg_data[DIR_W-1:0]);
        CFG_PLANE_Y:      plane_y_r <= $signed(cfg_data[DIR_W-1:0]);
        default: ;
      endcase
    end
  end

  logic             en;
  logic             space;
  logic [NST-1:0]   vld_r;
  logic [SW_W-1:0]  wdiv;

  assign en          = space;
  assign in_ch.ready = en;
  assign wdiv        = (sw_r == '0) ? SW_W'(1) : sw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_ch.valid};
    end
  end

  logic [SW_W-1:0] cd_rem [0:NUMW];
  logic [NUMW-1:0] cd_nq  [0:NUMW];

  assign cd_rem[0] = '0;
  assign cd_nq[0]  = {in_ch.column, 1'b0, {FB{1'b0}}};

  for (genvar k = 0; k < NUMW; k++) begin : g_cam
    rdc_div_cell #(.DW(SW_W), .QW(NUMW)) u_cell (
      .clk   (clk),
      .en    (en),
      .div_i (wdiv),
      .rem_i (cd_rem[k]),
      .nq_i  (cd_nq[k]),
      .rem_o (cd_rem[k+1]),
      .nq_o  (cd_nq[k+1])
    );
  end

  logic signed [CAMW-1:0] cam;
  logic signed [PRW-1:0]  px_r, py_r;

  assign cam = $signed({1'b0, cd_nq[NUMW]}) - ONE_CAM;

  always_ff @(posedge clk) begin
    if (en) begin
      px_r <= plane_x_r * cam;
      py_r <= plane_y_r * cam;
    end
  end

  function automatic logic signed [RAY_W-1:0] sat_ray(input logic signed [SUMW-1:0] v);
    logic signed [RAY_W-1:0] r;
    if (v > $signed(SUMW'(RAY_MAX))) begin
      r = RAY_W'(RAY_MAX);
    end else if (v < $signed(SUMW'(RAY_MIN))) begin
      r = RAY_W'(RAY_MIN);
    end else begin
      r = v[RAY_W-1:0];
    end
    return r;
  endfunction

  rdc_ctx_t              ctx_r [S_R:S_E];
  rdc_ctx_t              ctx_nxt;
  logic signed [SUMW-1:0] sum_x, sum_y;

  always_comb begin
    sum_x        = SUMW'(dir_x_r) + SUMW'(px_r >>> FB);
    sum_y        = SUMW'(dir_y_r) + SUMW'(py_r >>> FB);
    ctx_nxt.rx   = sat_ray(sum_x);
    ctx_nxt.ry   = sat_ray(sum_y);
    ctx_nxt.ax   = ctx_nxt.rx[RAY_W-1] ? RAY_W'(-ctx_nxt.rx) : RAY_W'(ctx_nxt.rx);
    ctx_nxt.ay   = ctx_nxt.ry[RAY_W-1] ? RAY_W'(-ctx_nxt.ry) : RAY_W'(ctx_nxt.ry);
    ctx_nxt.ovfx = 1'b0;
    ctx_nxt.ovfy = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_r[S_R] <= ctx_nxt;
    end
  end

  logic [2*RAY_W-1:0] ax2_r, ay2_r;
  logic [2*RAY_W:0]   sq_sum;
  logic [RAD_W-1:0]   rad_r;

  assign sq_sum = {1'b0, ax2_r} + {1'b0, ay2_r};

  always_ff @(posedge clk) begin
    if (en) begin
      ax2_r <= ctx_r[S_R].ax * ctx_r[S_R].ax;
      ay2_r <= ctx_r[S_R].ay * ctx_r[S_R].ay;
      rad_r <= {sq_sum[RAD_W-SQ_SHIFT-1:0], {SQ_SHIFT{1'b0}}};
    end
  end

  logic [RAD_W-1:0]  sq_rad  [0:ROOT_W];
  logic [ROOT_W:0]   sq_rem  [0:ROOT_W];
  logic [ROOT_W-1:0] sq_root [0:ROOT_W];

  assign sq_rad[0]  = rad_r;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    rdc_sqrt_cell u_cell (
      .clk    (clk),
      .en     (en),
      .rad_i  (sq_rad[k]),
      .rem_i  (sq_rem[k]),
      .root_i (sq_root[k]),
      .rad_o  (sq_rad[k+1]),
      .rem_o  (sq_rem[k+1]),
      .root_o (sq_root[k+1])
    );
  end

  logic [ROOT_W+FB-1:0] nfull;
  logic [DIST_W-1:0]    n_hi;
  logic [DIST_W-1:0]    dvs_x, dvs_y;
  logic                 ovfx, ovfy;
  logic [DIST_W-1:0]    dvx_rem [0:DIST_W];
  logic [DIST_W-1:0]    dvx_nq  [0:DIST_W];
  logic [DIST_W-1:0]    dvy_rem [0:DIST_W];
  logic [DIST_W-1:0]    dvy_nq  [0:DIST_W];

  always_comb begin
    nfull = {sq_root[ROOT_W], {FB{1'b0}}};
    n_hi  = DIST_W'(nfull[ROOT_W+FB-1:DIST_W]);
    dvs_x = {ctx_r[S_D0-1].ax, {EXTRA_BITS{1'b0}}};
    dvs_y = {ctx_r[S_D0-1].ay, {EXTRA_BITS{1'b0}}};
    ovfx  = (n_hi >= dvs_x);
    ovfy  = (n_hi >= dvs_y);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dvx_rem[0] <= n_hi;
      dvy_rem[0] <= n_hi;
      dvx_nq[0]  <= nfull[DIST_W-1:0];
      dvy_nq[0]  <= nfull[DIST_W-1:0];
    end
  end

  for (genvar i = S_Q1; i <= S_E; i++) begin : g_ctx
    if (i == S_D0) begin : g_mark
      always_ff @(posedge clk) begin
        if (en) begin
          ctx_r[i] <= {ctx_r[i-1].rx, ctx_r[i-1].ry, ctx_r[i-1].ax, ctx_r[i-1].ay,
                       ovfx, ovfy};
        end
      end
    end else begin : g_pass
      always_ff @(posedge clk) begin
        if (en) begin
          ctx_r[i] <= ctx_r[i-1];
        end
      end
    end
  end

  for (genvar k = 0; k < DIST_W; k++) begin : g_delta
    rdc_div_cell #(.DW(DIST_W), .QW(DIST_W)) u_cell_x (
      .clk   (clk),
      .en    (en),
      .div_i ({ctx_r[S_D0+k].ax, {EXTRA_BITS{1'b0}}}),
      .rem_i (dvx_rem[k]),
      .nq_i  (dvx_nq[k]),
      .rem_o (dvx_rem[k+1]),
      .nq_o  (dvx_nq[k+1])
    );
    rdc_div_cell #(.DW(DIST_W), .QW(DIST_W)) u_cell_y (
      .clk   (clk),
      .en    (en),
      .div_i ({ctx_r[S_D0+k].ay, {EXTRA_BITS{1'b0}}}),
      .rem_i (dvy_rem[k]),
      .nq_i  (dvy_nq[k]),
      .rem_o (dvy_rem[k+1]),
      .nq_o  (dvy_nq[k+1])
    );
  end

  logic [POS_W+FB-1:0] posx_w, posy_w;
  logic [FB:0]         frac_x, frac_y, fac_x, fac_y;
  logic [DIST_W-1:0]   dl_x, dl_y, dlx_r, dly_r;
  logic [PROW-1:0]     prod_x_r, prod_y_r;
  rdc_ctx_t            ce;

  always_comb begin
    ce     = ctx_r[S_E-1];
    posx_w = {{FB{1'b0}}, pos_x_r};
    posy_w = {{FB{1'b0}}, pos_y_r};
    frac_x = {1'b0, posx_w[FB-1:0]};
    frac_y = {1'b0, posy_w[FB-1:0]};
    fac_x  = ce.rx[RAY_W-1] ? frac_x : (FB+1)'(ONE_FR - frac_x);
    fac_y  = ce.ry[RAY_W-1] ? frac_y : (FB+1)'(ONE_FR - frac_y);
    dl_x   = ce.ovfx ? '1 : dvx_nq[DIST_W];
    dl_y   = ce.ovfy ? '1 : dvy_nq[DIST_W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dlx_r    <= dl_x;
      dly_r    <= dl_y;
      prod_x_r <= fac_x * dl_x;
      prod_y_r <= fac_y * dl_y;
    end
  end

  logic [POS_W-1:0] ip_x, ip_y, cl_x, cl_y;
  rdc_ctx_t         cf;
  rdc_result_t      res_nxt, res_r;

  always_comb begin
    cf   = ctx_r[S_E];
    ip_x = posx_w[POS_W+FB-1:FB];
    ip_y = posy_w[POS_W+FB-1:FB];
    cl_x = (ip_x > POS_W'(MAP_SIZE-1)) ? POS_W'(MAP_SIZE-1) : ip_x;
    cl_y = (ip_y > POS_W'(MAP_SIZE-1)) ? POS_W'(MAP_SIZE-1) : ip_y;
    res_nxt.ray_dir_x    = cf.rx;
    res_nxt.ray_dir_y    = cf.ry;
    res_nxt.cell_x       = cl_x[CELL_W-1:0];
    res_nxt.cell_y       = cl_y[CELL_W-1:0];
    res_nxt.step_neg_x   = cf.rx[RAY_W-1];
    res_nxt.step_neg_y   = cf.ry[RAY_W-1];
    res_nxt.delta_dist_x = dlx_r;
    res_nxt.delta_dist_y = dly_r;
    if (cf.rx == '0 || prod_x_r[PROW-1:FB+DIST_W] != '0) begin
      res_nxt.side_dist_x = '1;
    end else begin
      res_nxt.side_dist_x = prod_x_r[FB+DIST_W-1:FB];
    end
    if (cf.ry == '0 || prod_y_r[PROW-1:FB+DIST_W] != '0) begin
      res_nxt.side_dist_y = '1;
    end else begin
      res_nxt.side_dist_y = prod_y_r[FB+DIST_W-1:FB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  rdc_out_buf u_out_buf (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (vld_r[S_F] && en),
    .data_i  (res_r),
    .space_o (space),
    .out_ch  (out_ch)
  );

`ifndef SYNTHESIS
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.ready && out_ch.valid) |=> in_ch.ready)
    else $error("input held although output drained");

  a_zero_ray_x: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ray_dir_x == '0) |->
    (out_ch.delta_dist_x == '1 && out_ch.side_dist_x == '1 && !out_ch.step_neg_x))
    else $error("zero x ray not saturated");

  a_step_sign_y: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.step_neg_y == out_ch.ray_dir_y[RAY_W-1]))
    else $error("y step sign mismatch");
`endif

endmodule
`default_nettype wire

// ===== tb/raycast_dda_column_setup_unit_tb.sv =====
`timescale 1ns / 100ps
module raycast_dda_column_setup_unit_tb;
  import rdc_pkg::*;

  localparam int FRAC = 16;
  localparam int LATENCY = 12 + FRAC + 72;
  localparam int CYCLE_LIMIT = 400000;
  localparam longint unsigned DIST_SAT = 64'hFFFF_FFFF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  cfg_idx_t cfg_idx = CFG_SCREEN_WIDTH;
  logic [CFG_DW-1:0] cfg_data = '0;

  rdc_in_if #(.COLUMN_BITS(12)) in_ch ();
  rdc_out_if out_ch ();

  raycast_dda_column_setup_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [SW_W-1:0] m_width;
  logic [POS_W-1:0] m_pos_x, m_pos_y;
  logic signed [DIR_W-1:0] m_dir_x, m_dir_y, m_plane_x, m_plane_y;

  logic [11:0] column_q[$];
  rdc_result_t setup_q[$];
  int errors = 0;
  int cycles = 0;
  bit quiet = 1'b0;

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned abs_val(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint unsigned cell_delta(longint a, longint b);
    longint unsigned ma, mb, len, q;
    ma = abs_val(a);
    mb = abs_val(b);
    if (ma == 0) return DIST_SAT;
    len = int_sqrt((ma * ma + mb * mb) << SQ_SHIFT);
    q = (len << FRAC) / (ma << EXTRA_BITS);
    return (q > DIST_SAT) ? DIST_SAT : q;
  endfunction

  function automatic longint unsigned first_side(longint unsigned pos, longint ray,
                                                 longint unsigned delta);
    longint unsigned frac, factor, s;
    frac = pos & ((64'd1 << FRAC) - 1);
    if (ray == 0) return DIST_SAT;
    factor = (ray < 0) ? frac : ((64'd1 << FRAC) - frac);
    s = (factor * delta) >> FRAC;
    return (s > DIST_SAT) ? DIST_SAT : s;
  endfunction

  function automatic longint clamp_ray(longint v);
    if (v > RAY_MAX) return RAY_MAX;
    if (v < RAY_MIN) return RAY_MIN;
    return v;
  endfunction

  function automatic logic [CELL_W-1:0] map_cell(longint unsigned pos);
    longint unsigned ip;
    ip = pos >> FRAC;
    if (ip > 63) ip = 63;
    return ip[CELL_W-1:0];
  endfunction

  function automatic rdc_result_t column_setup(logic [11:0] col);
    rdc_result_t r;
    longint unsigned w, dx, dy;
    longint cam, rx, ry;
    w = (m_width == 0) ? 1 : longint'(m_width);
    cam = longint'(((longint'(col) * 2) << FRAC) / w) - (longint'(1) << FRAC);
    rx = clamp_ray(longint'(m_dir_x) + ((longint'(m_plane_x) * cam) >>> FRAC));
    ry = clamp_ray(longint'(m_dir_y) + ((longint'(m_plane_y) * cam) >>> FRAC));
    dx = cell_delta(rx, ry);
    dy = cell_delta(ry, rx);
    r.ray_dir_x = rx[RAY_W-1:0];
    r.ray_dir_y = ry[RAY_W-1:0];
    r.cell_x = map_cell(m_pos_x);
    r.cell_y = map_cell(m_pos_y);
    r.step_neg_x = rx < 0;
    r.step_neg_y = ry < 0;
    r.delta_dist_x = dx[DIST_W-1:0];
    r.delta_dist_y = dy[DIST_W-1:0];
    r.side_dist_x = DIST_W'(first_side(m_pos_x, rx, dx));
    r.side_dist_y = DIST_W'(first_side(m_pos_y, ry, dy));
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("raycast_dda_column_setup_unit regression: fail");
      $finish;
    end
  end

  // drive requests from the pending queue
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        setup_q.push_back(column_setup(in_ch.column));
        void'(column_q.pop_front());
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (column_q.size() > 0 && (quiet || $urandom_range(99) >= 8)) begin
          in_ch.valid <= 1'b1;
          in_ch.column <= column_q[0];
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, longint unsigned e, longint unsigned a);
    if (e != a) begin
      errors++;
      $display("%0t %s mismatch: expected %h actual %h", $realtime, name, e, a);
    end
  endtask

  always @(posedge clk) begin
    rdc_result_t e;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (setup_q.size() == 0) begin
          errors++;
          $display("%0t unexpected result: expected none actual %h", $realtime,
                   out_ch.ray_dir_x);
        end else begin
          e = setup_q.pop_front();
          check_field("ray_dir_x", e.ray_dir_x, out_ch.ray_dir_x);
          check_field("ray_dir_y", e.ray_dir_y, out_ch.ray_dir_y);
          check_field("cell_x", e.cell_x, out_ch.cell_x);
          check_field("cell_y", e.cell_y, out_ch.cell_y);
          check_field("step_neg_x", e.step_neg_x, out_ch.step_neg_x);
          check_field("step_neg_y", e.step_neg_y, out_ch.step_neg_y);
          check_field("delta_dist_x", e.delta_dist_x, out_ch.delta_dist_x);
          check_field("delta_dist_y", e.delta_dist_y, out_ch.delta_dist_y);
          check_field("side_dist_x", e.side_dist_x, out_ch.side_dist_x);
          check_field("side_dist_y", e.side_dist_y, out_ch.side_dist_y);
        end
      end
      out_ch.ready <= quiet || ($urandom_range(99) >= 8);
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DW-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      CFG_SCREEN_WIDTH: m_width = data[SW_W-1:0];
      CFG_POS_X: m_pos_x = data[POS_W-1:0];
      CFG_POS_Y: m_pos_y = data[POS_W-1:0];
      CFG_DIR_X: m_dir_x = data[DIR_W-1:0];
      CFG_DIR_Y: m_dir_y = data[DIR_W-1:0];
      CFG_PLANE_X: m_plane_x = data[DIR_W-1:0];
      CFG_PLANE_Y: m_plane_y = data[DIR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_camera(int w, int px, int py, int dx, int dy, int plx, int ply);
    write_reg(CFG_SCREEN_WIDTH, CFG_DW'(w));
    write_reg(CFG_POS_X, CFG_DW'(px));
    write_reg(CFG_POS_Y, CFG_DW'(py));
    write_reg(CFG_DIR_X, CFG_DW'(dx));
    write_reg(CFG_DIR_Y, CFG_DW'(dy));
    write_reg(CFG_PLANE_X, CFG_DW'(plx));
    write_reg(CFG_PLANE_Y, CFG_DW'(ply));
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (column_q.size() != 0 || setup_q.size() != 0 || in_ch.valid) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int w, n;
    in_ch.valid = 1'b0;
    in_ch.column = '0;
    out_ch.ready = 1'b0;
    m_width = RST_SCREEN_WIDTH;
    m_pos_x = RST_POS;
    m_pos_y = RST_POS;
    m_dir_x = RST_DIR_X;
    m_dir_y = RST_DIR_Y;
    m_plane_x = RST_PLANE_X;
    m_plane_y = RST_PLANE_Y;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    column_q.push_back(12'd0);
    column_q.push_back(12'd1);
    column_q.push_back(12'd319);
    column_q.push_back(12'd320);
    column_q.push_back(12'd639);
    column_q.push_back(12'd640);
    column_q.push_back(12'd4095);
    drain();
    // zero width, saturating ray, far corner of the map
    load_camera(0, 22'h3FFFFF, 22'h3FFFFF, 131071, -131072, 131071, -131072);
    column_q.push_back(12'd0);
    column_q.push_back(12'd1);
    column_q.push_back(12'd4095);
    drain();
    load_camera(4096, 22'h010000, 22'h0, -131072, 131071, -131072, 131071);
    column_q.push_back(12'd0);
    column_q.push_back(12'd2048);
    column_q.push_back(12'd4095);
    drain();
    // zero ray on both axes, then on one axis
    load_camera(8191, 22'h12345, 22'h2ABCD, 0, 0, 0, 0);
    column_q.push_back(12'd100);
    column_q.push_back(12'd4095);
    drain();
    load_camera(64, 22'h08000, 22'h18000, 0, 65536, 0, 43254);
    column_q.push_back(12'd3);
    column_q.push_back(12'd63);
    column_q.push_back(12'd32);
    drain();
    load_camera(2, 22'h1FFFF, 22'h3F0001, 65536, 0, 0, 43254);
    column_q.push_back(12'd1);
    column_q.push_back(12'd2);
    column_q.push_back(12'd3);
    drain();

    for (int ph = 0; ph < 13; ph++) begin
      quiet = (ph == 6);
      case ($urandom_range(7))
        0: w = 0;
        1: w = $urandom_range(8191);
        2: w = $urandom_range(16) + 1;
        default: w = $urandom_range(4096, 1);
      endcase
      load_camera(w, $urandom, $urandom,
                  ($urandom_range(4) == 0) ? 0 : $urandom,
                  ($urandom_range(4) == 0) ? 0 : $urandom,
                  ($urandom_range(4) == 0) ? 0 : $urandom,
                  ($urandom_range(4) == 0) ? 0 : $urandom);
      n = 50 + $urandom_range(10);
      for (int k = 0; k < n; k++) begin
        if (w > 1 && $urandom_range(9) != 0) column_q.push_back(12'($urandom_range(w - 1)));
        else column_q.push_back(12'($urandom));
      end
      drain();
    end
    quiet = 1'b0;
    repeat (LATENCY + 20) @(posedge clk);

    if (errors == 0 && setup_q.size() == 0) begin
      $display("raycast_dda_column_setup_unit regression: pass");
    end else begin
      $display("raycast_dda_column_setup_unit regression: fail");
    end
    $finish;
  end

endmodule

// ===== raycast_dda_column_setup_unit.f =====
rtl/rdc_pkg.sv
rtl/rdc_in_if.sv
rtl/rdc_out_if.sv
rtl/rdc_div_cell.sv
rtl/rdc_sqrt_cell.sv
rtl/rdc_out_buf.sv
rtl/raycast_dda_column_setup_unit.sv
tb/raycast_dda_column_setup_unit_tb.sv
